// ===== src/tsrtp_pkg.sv =====
// Package with shared types and constants of the TS to TTS RTP packetiser.
package tsrtp_pkg;

    // Transport stream framing and grouping.
    localparam int unsigned TS_PACKET_BYTES  = 188;
    localparam int unsigned UNITS_PER_PACKET = 6;
    localparam logic [7:0]  SYNC_BYTE        = 8'h47;
    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0]  MARKER_BIT       = 8'h80;

    // Widths of internal counters.
    localparam int unsigned POS_W   = 8;
    localparam int unsigned UNITS_W = 3;
    localparam int unsigned IDX_W   = 5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RTP_PT         = 2'd0;
    localparam logic [1:0] CFG_SYNC_SOURCE_ID = 2'd1;
    localparam logic [1:0] CFG_TIMECODE_STEP  = 2'd2;
    localparam logic [1:0] CFG_TIMESTAMP_STEP = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [6:0]  PT_RESET        = 7'd103;
    localparam logic [31:0] SSRC_RESET      = 32'h0000_1234;
    localparam logic [15:0] TC_STEP_RESET   = 16'd300;
    localparam logic [15:0] TS_STEP_RESET   = 16'd3003;

    // Byte positions within one emitted burst: header, timecode, payload byte.
    localparam logic [IDX_W-1:0] IDX_HEADER   = 5'd0;
    localparam logic [IDX_W-1:0] IDX_TIMECODE = 5'd12;
    localparam logic [IDX_W-1:0] IDX_DATA     = 5'd16;

    // Input request payload.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_buffer;
        logic [15:0] bytes_remaining;
    } t_in_item;

    // Output request payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_packet;
    } t_out_item;

    // Everything needed to emit the bytes caused by one input byte.
    typedef struct packed {
        logic [6:0]  rtp_pt;
        logic [15:0] sequence_number;
        logic [31:0] rtp_timestamp;
        logic [31:0] sync_source_id;
        logic [31:0] unit_timecode;
        logic [7:0]  data_byte;
        logic        last_of_packet;
    } t_job;

endpackage

// ===== src/ts_to_tts_rtp_packetizer.sv =====
// Top level of the TS to 192-byte TTS RTP packetiser.

// Each accepted transport stream byte is judged in the cycle it is accepted and
// causes zero, one, five or seventeen output bytes, which a byte emitter sends
// one per cycle through an output register while the receiver takes them. Inside
// a kept chunk a payload byte can be accepted every cycle while the output does
// not stall; the first byte of a kept chunk occupies the emitter for its timecode
// and byte, or its RTP header, timecode and byte, and the next input is taken in
// the cycle the emitter sends that burst's last byte. Dropped bytes leave the
// emitter free. The output side is registered, so input acceptance continues
// while a finished byte waits to be taken. Configuration writes land at once and
// should be made while the block is idle.
module ts_to_tts_rtp_packetizer
    import tsrtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    // Configuration registers.
    logic [6:0]  r_rtp_pt;
    logic [31:0] r_sync_source_id;
    logic [15:0] r_timecode_step;
    logic [15:0] r_timestamp_step;

    // Packetiser state.
    logic [POS_W-1:0]   r_chunk_pos, n_chunk_pos;
    logic               r_chunk_kept, n_chunk_kept;
    logic [UNITS_W-1:0] r_units, n_units;
    logic [15:0]        r_seq, n_seq;
    logic [31:0]        r_ts, n_ts;
    logic [31:0]        r_tc, n_tc;

    // Emitter.
    logic               r_job_valid;
    t_job               r_job, n_job;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               n_emit;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               accept;
    logic               move;
    logic [7:0]         emit_byte;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rtp_pt         <= PT_RESET;
            r_sync_source_id <= SSRC_RESET;
            r_timecode_step  <= TC_STEP_RESET;
            r_timestamp_step <= TS_STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RTP_PT:         r_rtp_pt         <= i_cfg_data[6:0];
                CFG_SYNC_SOURCE_ID: r_sync_source_id <= i_cfg_data;
                CFG_TIMECODE_STEP:  r_timecode_step  <= i_cfg_data[15:0];
                CFG_TIMESTAMP_STEP: r_timestamp_step <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The emitter moves a byte whenever the output register is free or drains.
    assign move       = r_job_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_job_valid || (move && (r_idx == IDX_DATA));
    assign accept     = i_in_valid && o_in_ready;

    // Chunking, filtering and RTP state for one accepted byte.
    always_comb begin
        logic [POS_W-1:0]   pos;
        logic               kept;
        logic [UNITS_W-1:0] units;
        logic               start_kept;
        logic               last;

        pos        = r_chunk_pos;
        kept       = r_chunk_kept;
        units      = r_units;
        start_kept = 1'b0;
        last       = 1'b0;
        n_seq      = r_seq;
        n_ts       = r_ts;
        n_tc       = r_tc;
        n_idx      = IDX_DATA;

        // A buffer mark restarts alignment and abandons a truncated unit.
        if (i_in_data.first_of_buffer) begin
            if (kept && (pos != '0)) begin
                units = '0;
            end
            pos  = '0;
            kept = 1'b0;
        end

        // First byte of a chunk: decide whether it is kept.
        if (pos == '0) begin
            kept = (i_in_data.data_byte == SYNC_BYTE) &&
                   (i_in_data.bytes_remaining >= 16'(TS_PACKET_BYTES));
            if (kept) begin
                start_kept = 1'b1;
                n_tc       = r_tc + {16'd0, r_timecode_step};
                n_idx      = (units == '0) ? IDX_HEADER : IDX_TIMECODE;
            end
        end

        // Job snapshot taken before the counters advance.
        n_job.rtp_pt          = r_rtp_pt;
        n_job.sequence_number = r_seq;
        n_job.rtp_timestamp   = r_ts;
        n_job.sync_source_id  = r_sync_source_id;
        n_job.unit_timecode   = r_tc;
        n_job.data_byte       = i_in_data.data_byte;
        n_emit                = kept;

        // Last byte of a chunk closes a unit and maybe a packet.
        if (pos >= POS_W'(TS_PACKET_BYTES - 1)) begin
            if (kept) begin
                if (units == UNITS_W'(UNITS_PER_PACKET - 1)) begin
                    last  = 1'b1;
                    units = '0;
                    n_seq = r_seq + 16'd1;
                    n_ts  = r_ts + {16'd0, r_timestamp_step};
                end else begin
                    units = units + UNITS_W'(1);
                end
            end
            pos  = '0;
            kept = 1'b0;
        end else begin
            pos = pos + POS_W'(1);
        end

        n_job.last_of_packet = last;
        n_chunk_pos          = pos;
        n_chunk_kept         = kept;
        n_units              = units;
        // Only a kept chunk's first byte takes the timecode step.
        if (!start_kept) begin
            n_tc = r_tc;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_pos  <= '0;
            r_chunk_kept <= 1'b0;
            r_units      <= '0;
            r_seq        <= '0;
            r_ts         <= '0;
            r_tc         <= '0;
        end else if (accept) begin
            r_chunk_pos  <= n_chunk_pos;
            r_chunk_kept <= n_chunk_kept;
            r_units      <= n_units;
            r_seq        <= n_seq;
            r_ts         <= n_ts;
            r_tc         <= n_tc;
        end
    end

    // Byte selection for the current burst position.
    always_comb begin
        case (r_idx)
            5'd0:    emit_byte = RTP_VERSION_BYTE;
            5'd1:    emit_byte = MARKER_BIT | {1'b0, r_job.rtp_pt};
            5'd2:    emit_byte = r_job.sequence_number[15:8];
            5'd3:    emit_byte = r_job.sequence_number[7:0];
            5'd4:    emit_byte = r_job.rtp_timestamp[31:24];
            5'd5:    emit_byte = r_job.rtp_timestamp[23:16];
            5'd6:    emit_byte = r_job.rtp_timestamp[15:8];
            5'd7:    emit_byte = r_job.rtp_timestamp[7:0];
            5'd8:    emit_byte = r_job.sync_source_id[31:24];
            5'd9:    emit_byte = r_job.sync_source_id[23:16];
            5'd10:   emit_byte = r_job.sync_source_id[15:8];
            5'd11:   emit_byte = r_job.sync_source_id[7:0];
            5'd12:   emit_byte = r_job.unit_timecode[31:24];
            5'd13:   emit_byte = r_job.unit_timecode[23:16];
            5'd14:   emit_byte = r_job.unit_timecode[15:8];
            5'd15:   emit_byte = r_job.unit_timecode[7:0];
            default: emit_byte = r_job.data_byte;
        endcase
    end

    // Burst register: loaded on a kept byte, stepped on each emitted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= IDX_DATA;
        end else if (accept && n_emit) begin
            r_job_valid <= 1'b1;
            r_idx       <= n_idx;
        end else if (move) begin
            if (r_idx == IDX_DATA) begin
                r_job_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_job <= n_job;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out.out_byte       <= emit_byte;
            r_out.last_of_packet <= (r_idx == IDX_DATA) && r_job.last_of_packet;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The open group never reaches a full packet without closing.
    a_units_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_units < UNITS_W'(UNITS_PER_PACKET))
        else $error("units_in_group out of range");

    // A kept chunk is always past its first byte between requests.
    a_kept_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk_kept |-> (r_chunk_pos != '0))
        else $error("kept chunk at position zero");

    // A burst never runs past its payload byte.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_idx <= IDX_DATA))
        else $error("burst index past payload byte");

    // A new request is taken only as the burst hands over its final byte.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && r_job_valid) |-> (move && (r_idx == IDX_DATA)))
        else $error("request accepted over an open burst");

endmodule

// ===== test/ts_to_tts_rtp_packetizer_test.sv =====
// Self-checking testbench for the TS to TTS RTP packetiser, with a byte-level predictor.
module ts_to_tts_rtp_packetizer_test;
    import tsrtp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Idle cycles added after every byte has arrived, before settle() returns.
    localparam int unsigned SETTLE_CYCLES = 24;
    // Cycles without any accepted request or output byte before the run is declared hung.
    localparam int unsigned QUIET_LIMIT   = 1000;
    // Well-formed chunks of random traffic per configuration phase.
    localparam int unsigned PHASE_CHUNKS  = 36;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_RTP_PT;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;

    ts_to_tts_rtp_packetizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Transport stream requests waiting to be sent, and RTP bytes still to arrive.
    t_in_item  ts_bytes_pending[$];
    t_out_item rtp_bytes_due[$];
    int unsigned mismatches = 0;

    // Predictor copy of the configuration registers.
    logic [6:0]  cfg_rtp_pt  = PT_RESET;
    logic [31:0] cfg_ssrc    = SSRC_RESET;
    logic [15:0] cfg_tc_step = TC_STEP_RESET;
    logic [15:0] cfg_ts_step = TS_STEP_RESET;

    // Predictor copy of the packetiser state.
    logic [POS_W-1:0]   chunk_pos   = '0;
    logic               chunk_keep  = 1'b0;
    logic [UNITS_W-1:0] group_units = '0;
    logic [15:0]        seq_no      = '0;
    logic [31:0]        rtp_ts      = '0;
    logic [31:0]        unit_tc     = '0;

    // Sender burst and gap counters, receiver stall pattern, watchdog.
    int unsigned burst_left   = 1;
    int unsigned gap_left     = 0;
    t_rx_mode    rx_mode      = RX_OPEN;
    int unsigned rx_left      = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void push_rtp_byte(logic [7:0] value, logic last);
        rtp_bytes_due.push_back({value, last});
    endfunction

    function automatic void push_rtp_word(logic [31:0] value);
        for (int b = 3; b >= 0; b--)
            push_rtp_byte(value[8*b +: 8], 1'b0);
    endfunction

    // Work out the RTP bytes that one accepted transport stream byte causes.
    function automatic void pack_rtp_bytes(t_in_item ts);
        logic last;
        last = 1'b0;
        // A buffer mark restarts chunking; a kept unit cut short abandons its group.
        if (ts.first_of_buffer) begin
            if (chunk_keep && chunk_pos != 0)
                group_units = '0;
            chunk_pos  = '0;
            chunk_keep = 1'b0;
        end
        // The first byte of a chunk decides whether the chunk is wrapped or dropped.
        if (chunk_pos == 0) begin
            chunk_keep = (ts.data_byte == SYNC_BYTE) && (ts.bytes_remaining >= TS_PACKET_BYTES);
            if (chunk_keep) begin
                if (group_units == 0) begin
                    push_rtp_byte(RTP_VERSION_BYTE, 1'b0);
                    push_rtp_byte(MARKER_BIT | {1'b0, cfg_rtp_pt}, 1'b0);
                    push_rtp_byte(seq_no[15:8], 1'b0);
                    push_rtp_byte(seq_no[7:0], 1'b0);
                    push_rtp_word(rtp_ts);
                    push_rtp_word(cfg_ssrc);
                end
                push_rtp_word(unit_tc);
                unit_tc = unit_tc + cfg_tc_step;
            end
        end
        // The last byte of a chunk closes the unit and possibly the packet.
        if (chunk_pos >= TS_PACKET_BYTES - 1) begin
            if (chunk_keep) begin
                if (group_units + 1 >= UNITS_PER_PACKET) begin
                    last        = 1'b1;
                    group_units = '0;
                    seq_no      = seq_no + 16'd1;
                    rtp_ts      = rtp_ts + cfg_ts_step;
                end else begin
                    group_units = group_units + 1'b1;
                end
                push_rtp_byte(ts.data_byte, last);
            end
            chunk_pos  = '0;
            chunk_keep = 1'b0;
        end else begin
            if (chunk_keep)
                push_rtp_byte(ts.data_byte, 1'b0);
            chunk_pos = chunk_pos + 1'b1;
        end
    endfunction

    // Queue one buffer: sent bytes, claimed length and the chance of a bad sync byte.
    task automatic add_buffer(int unsigned n_sent, int unsigned n_claim, bit marked,
                              int unsigned bad_sync_pct);
        t_in_item ts;
        for (int unsigned k = 0; k < n_sent; k++) begin
            ts.data_byte = 8'($urandom_range(0, 255));
            if (k % TS_PACKET_BYTES == 0) begin
                if ($urandom_range(0, 99) < bad_sync_pct) begin
                    if (ts.data_byte == SYNC_BYTE)
                        ts.data_byte = 8'h00;
                end else begin
                    ts.data_byte = SYNC_BYTE;
                end
            end
            ts.first_of_buffer = marked && (k == 0);
            ts.bytes_remaining = (n_claim - k > 65535) ? 16'hFFFF : 16'(n_claim - k);
            ts_bytes_pending.push_back(ts);
        end
    endtask

    // Queue bytes with random content, marks and remaining counts.
    task automatic add_noise(int unsigned n);
        t_in_item ts;
        repeat (n) begin
            ts.data_byte       = ($urandom_range(0, 3) == 0) ? SYNC_BYTE
                                                            : 8'($urandom_range(0, 255));
            ts.first_of_buffer = ($urandom_range(0, 15) == 0);
            ts.bytes_remaining = $urandom_range(0, 1) ? 16'($urandom_range(0, 400))
                                                      : 16'($urandom);
            ts_bytes_pending.push_back(ts);
        end
    endtask

    // Queue one random buffer, mostly well formed; reports its well-formed chunks.
    task automatic add_random_buffer(output int unsigned good_chunks);
        int unsigned pick, n, claim, cut;
        pick        = $urandom_range(0, 19);
        good_chunks = 0;
        n           = $urandom_range(1, 6);
        cut         = $urandom_range(1, TS_PACKET_BYTES - 1);
        if (pick < 13) begin
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(7, 14);
            claim = n * TS_PACKET_BYTES;
            if ($urandom_range(0, 5) == 0)
                claim += 2 * $urandom_range(0, 65535);
            add_buffer(n * TS_PACKET_BYTES, claim, $urandom_range(0, 7) != 0, 0);
            good_chunks = n;
        end else if (pick < 15) begin
            add_buffer(n * TS_PACKET_BYTES, n * TS_PACKET_BYTES, 1'b1, 40);
        end else if (pick < 17) begin
            // Whole chunks followed by a short tail too small to form a chunk.
            n = $urandom_range(0, 3);
            add_buffer(n * TS_PACKET_BYTES + cut, n * TS_PACKET_BYTES + cut, 1'b1, 0);
        end else if (pick < 19) begin
            // A buffer that stops inside a chunk it promised to complete.
            n = $urandom_range(0, 3);
            add_buffer(n * TS_PACKET_BYTES + cut, (n + 1) * TS_PACKET_BYTES, 1'b1, 0);
        end else begin
            add_noise($urandom_range(1, 300));
        end
    endtask

    // Write one register in both the block and the predictor; only called while idle.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            CFG_RTP_PT:         cfg_rtp_pt  = value[6:0];
            CFG_SYNC_SOURCE_ID: cfg_ssrc    = value;
            CFG_TIMECODE_STEP:  cfg_tc_step = value[15:0];
            CFG_TIMESTAMP_STEP: cfg_ts_step = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every request is sent and every byte has come, then let the emitter rest.
    task automatic settle();
        while (ts_bytes_pending.size() != 0 || i_in_valid || rtp_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: present pending requests in bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                pack_rtp_bytes(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0 || ts_bytes_pending.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= ts_bytes_pending.pop_front();
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else if ($urandom_range(0, 3) == 0) begin
                        burst_left <= $urandom_range(100, 600);
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                                  : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: change the stall pattern every so often.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_HALF:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 7) == 0);
            default:   i_out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Monitor: compare each accepted RTP byte with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rtp_bytes_due.size() == 0) begin
                $error("out_byte %h arrived with nothing predicted", o_out_data.out_byte);
                mismatches++;
            end else begin
                want = rtp_bytes_due.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, actual %h",
                           want.out_byte, o_out_data.out_byte);
                    mismatches++;
                end
                if (o_out_data.last_of_packet !== want.last_of_packet) begin
                    $error("last_of_packet: expected %b, actual %b",
                           want.last_of_packet, o_out_data.last_of_packet);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no request moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: directed buffers at reset settings, then random traffic per setting.
    initial begin
        int unsigned chunks, got;

        // Stream opens without a buffer mark, then completes a group of six units.
        add_buffer(TS_PACKET_BYTES, TS_PACKET_BYTES, 1'b0, 0);
        add_buffer(5 * TS_PACKET_BYTES, 5 * TS_PACKET_BYTES, 1'b1, 0);
        // Bad sync byte, too short a remainder, and a zero remaining count.
        add_buffer(TS_PACKET_BYTES, TS_PACKET_BYTES, 1'b1, 100);
        add_buffer(TS_PACKET_BYTES - 1, TS_PACKET_BYTES - 1, 1'b1, 0);
        add_buffer(1, 0, 1'b1, 0);
        // A kept chunk cut by a mark, then a dropped chunk cut by a mark.
        add_buffer(100, TS_PACKET_BYTES, 1'b1, 0);
        add_buffer(50, 2 * TS_PACKET_BYTES, 1'b1, 100);
        // Saturated remaining count, then an unmarked buffer that finishes the group.
        add_buffer(2 * TS_PACKET_BYTES, 200000, 1'b1, 0);
        add_buffer(4 * TS_PACKET_BYTES, 4 * TS_PACKET_BYTES, 1'b0, 0);
        add_buffer(3, 200000, 1'b1, 100);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 1; phase <= 5; phase++) begin
            settle();
            case (phase)
                1: begin
                    write_reg(CFG_RTP_PT, 32'd127);
                    write_reg(CFG_SYNC_SOURCE_ID, 32'hFFFF_FFFF);
                    write_reg(CFG_TIMECODE_STEP, 32'hFFFF);
                    write_reg(CFG_TIMESTAMP_STEP, 32'hFFFF);
                end
                2: begin
                    write_reg(CFG_RTP_PT, 32'd0);
                    write_reg(CFG_SYNC_SOURCE_ID, 32'd0);
                    write_reg(CFG_TIMECODE_STEP, 32'd0);
                    write_reg(CFG_TIMESTAMP_STEP, 32'd0);
                end
                default: begin
                    // Upper bits of the write data are junk and must be ignored.
                    write_reg(CFG_RTP_PT, $urandom);
                    write_reg(CFG_SYNC_SOURCE_ID, $urandom);
                    write_reg(CFG_TIMECODE_STEP, $urandom);
                    write_reg(CFG_TIMESTAMP_STEP, $urandom);
                end
            endcase
            chunks = 0;
            while (chunks < PHASE_CHUNKS) begin
                add_random_buffer(got);
                chunks += got;
                // Now and then hold the sender until every byte has drained.
                if ($urandom_range(0, 11) == 0)
                    settle();
            end
        end

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tsrtp_pkg.sv
src/ts_to_tts_rtp_packetizer.sv
test/ts_to_tts_rtp_packetizer_test.sv
